FILE: rtl/assert_macros.svh
// Assertion macros shared by the encoder RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: rtl/ageg_pkg.sv
// Shared types, codes and constants for the adaptive Golomb encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ageg_pkg;

   localparam int MAX_DYNAMIC_RANGE = 16;
   localparam int SAMPLE_W          = 16;
   localparam int WORD_W            = 32;
   localparam int ACC_W             = 32;
   localparam int CNT_W             = 15;
   localparam int PEND_W            = 31;

   // register byte addresses
   localparam logic [3:0] CSR_DYN_RANGE  = 4'h0;
   localparam logic [3:0] CSR_UNARY_LIM  = 4'h4;
   localparam logic [3:0] CSR_ACC_INIT   = 4'h8;
   localparam logic [3:0] CSR_CNT_SIZE   = 4'hC;

   typedef enum logic [1:0] {
      REQ_IMAGE = 2'd0,
      REQ_BAND  = 2'd1,
      REQ_CODED = 2'd2,
      REQ_FLUSH = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_RAW,
      ST_ADAPT,
      ST_BOUND,
      ST_SEARCH,
      ST_CODE1,
      ST_CODE2,
      ST_FLUSH,
      ST_EMIT
   } seq_state_type;

   // effective (saturated) configuration
   typedef struct packed {
      logic [4:0] depth;
      logic [5:0] umax;
      logic [3:0] k0;
      logic [8:0] limit;
   } cfg_type;

   // bit append / flush request to the packer
   typedef struct packed {
      logic        valid;
      logic        flush;
      logic [5:0]  len;
      logic [31:0] value;
   } pack_cmd_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] word;
   } pack_out_type;

   // accumulator start value: ((3*2^(k0+6) - 49) * 2^k0) >> 7
   function automatic logic [ACC_W-1:0] init_accum(input logic [3:0] k0);
      logic [35:0] t;
      t = (36'd3 << ({1'b0, k0, 1'b0} + 6'd6)) - (36'd49 << k0);
      return ACC_W'(t[35:7]);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/adaptive_golomb_encoder_core.sv
// Adaptive Golomb encoder: mapped residuals in, packed 32-bit code words out.
//
// req channel: tuser = request kind (image start, band first, coded, flush),
// tdata = mapped residual. rsp channel: tdata = packed word, first bit in the
// MSB; tlast marks the last word produced by one request.
// A request is taken only when the block is idle; it then runs to the end,
// including delivery of its words, before req_tready rises again.
// States walked by one request before it returns to idle:
//   flush / band first     FLUSH or RAW, then EMIT (at most one word)
//   image start            INIT, RAW, then EMIT (at most one word)
//   coded sample           ADAPT, BOUND, SEARCH, CODE1, CODE2, EMIT, with
//                          k <= depth - 2 set by the one-compare-per-cycle
//                          code parameter search
// A request yields zero to two words. When rsp_tready is low the current word
// holds on the port and the block waits. Reset clears the coder state and
// pending bits and loads the register defaults; the CSR port writes at any
// time, but registers are meant to change only while idle.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_golomb_encoder_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,   // [15:0] sample
   input  wire logic [1:0]   req_tuser,   // [1:0] req_type
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,   // [31:0] code_word
   output logic              rsp_tlast,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import ageg_pkg::*;

   logic [4:0] dyn_range_ff, dyn_range_in;
   logic [5:0] unary_lim_ff, unary_lim_in;
   logic [3:0] acc_init_ff, acc_init_in;
   logic [2:0] cnt_size_ff, cnt_size_in;

   logic         csr_wr;
   logic [2:0]   cnt_size_sat;
   cfg_type      cfg;
   pack_cmd_type pk_cmd;
   pack_out_type pk_out;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      dyn_range_in = dyn_range_ff;
      unary_lim_in = unary_lim_ff;
      acc_init_in  = acc_init_ff;
      cnt_size_in  = cnt_size_ff;
      csr_prdata   = '0;
      unique case (csr_paddr)
         CSR_DYN_RANGE: begin
            csr_prdata = {27'd0, dyn_range_ff};
            if (csr_wr) dyn_range_in = csr_pwdata[4:0];
         end
         CSR_UNARY_LIM: begin
            csr_prdata = {26'd0, unary_lim_ff};
            if (csr_wr) unary_lim_in = csr_pwdata[5:0];
         end
         CSR_ACC_INIT: begin
            csr_prdata = {28'd0, acc_init_ff};
            if (csr_wr) acc_init_in = csr_pwdata[3:0];
         end
         CSR_CNT_SIZE: begin
            csr_prdata = {29'd0, cnt_size_ff};
            if (csr_wr) cnt_size_in = csr_pwdata[2:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dyn_range_ff <= 5'd16;
         unary_lim_ff <= 6'd16;
         acc_init_ff  <= 4'd4;
         cnt_size_ff  <= 3'd2;
      end else begin
         dyn_range_ff <= dyn_range_in;
         unary_lim_ff <= unary_lim_in;
         acc_init_ff  <= acc_init_in;
         cnt_size_ff  <= cnt_size_in;
      end
   end

   // saturate register values into their working ranges
   assign cnt_size_sat = (cnt_size_ff < 3'd1) ? 3'd1
                       : (cnt_size_ff > 3'd5) ? 3'd5 : cnt_size_ff;

   always_comb begin
      cfg.depth = ((dyn_range_ff == 5'd0) || (dyn_range_ff > 5'(MAX_DYNAMIC_RANGE)))
                ? 5'(MAX_DYNAMIC_RANGE) : dyn_range_ff;
      cfg.umax  = (unary_lim_ff < 6'd1) ? 6'd1
                : (unary_lim_ff > 6'd32) ? 6'd32 : unary_lim_ff;
      cfg.k0    = (acc_init_ff > 4'd14) ? 4'd14 : acc_init_ff;
      cfg.limit = 9'((10'd1 << ({1'b0, cnt_size_sat} + 4'd4)) - 10'd1);
   end

   ageg_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_sample (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .pk_cmd     (pk_cmd),
      .pk_out     (pk_out)
   );

   ageg_packer u_packer (
      .clock  (clock),
      .reset  (reset),
      .pk_cmd (pk_cmd),
      .pk_out (pk_out)
   );

endmodule

`default_nettype wire

FILE: rtl/ageg_packer.sv
// Bit packer: appends fields MSB first and cuts 32-bit words.
// Depends on ageg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ageg_packer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  ageg_pkg::pack_cmd_type     pk_cmd,
   output ageg_pkg::pack_out_type     pk_out
);
   import ageg_pkg::*;

   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [4:0]        count_ff, count_in;

   logic [31:0] val_masked;
   logic [62:0] acc;
   logic [5:0]  sum;
   logic [4:0]  rem;
   logic [62:0] flush_word;

   assign val_masked = pk_cmd.len[5] ? pk_cmd.value
                     : (pk_cmd.value & 32'((33'd1 << pk_cmd.len) - 33'd1));
   assign acc        = (63'(pend_ff) << pk_cmd.len) | 63'(val_masked);
   assign sum        = {1'b0, count_ff} + pk_cmd.len;
   assign rem        = sum[4:0];
   assign flush_word = {pend_ff, 32'd0} >> count_ff;

   always_comb begin
      pend_in  = pend_ff;
      count_in = count_ff;
      pk_out   = '0;
      if (pk_cmd.valid) begin
         if (pk_cmd.flush) begin
            if (count_ff != 5'd0) begin
               pk_out.valid = 1'b1;
               pk_out.word  = flush_word[31:0];
            end
            pend_in  = '0;
            count_in = '0;
         end else if (sum[5]) begin
            pk_out.valid = 1'b1;
            pk_out.word  = 32'(acc >> rem);
            pend_in      = acc[PEND_W-1:0] & PEND_W'((32'd1 << rem) - 32'd1);
            count_in     = rem;
         end else begin
            pend_in  = acc[PEND_W-1:0];
            count_in = sum[4:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         count_ff <= '0;
      end else begin
         pend_ff  <= pend_in;
         count_ff <= count_in;
      end
   end

   `include "assert_macros.svh"

   `ASSERT_HOLDS(a_pend_clean, clock, reset, ((63'(pend_ff) >> count_ff) == 63'd0), "stale bits above pending count")
   `ASSERT_HOLDS(a_flush_clears, clock, reset, (pk_cmd.valid && pk_cmd.flush) |=> (count_ff == 5'd0), "flush left bits pending")

endmodule

`default_nettype wire

FILE: rtl/ageg_seq.sv
// Sequencer: adaptation, iterative code parameter search, word buffer.
// Depends on ageg_pkg; drives ageg_packer through pack_cmd_type.
`timescale 1ns / 1ps
`default_nettype none

module ageg_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  ageg_pkg::cfg_type          cfg,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [1:0]            req_kind,
   input  wire logic [15:0]           req_sample,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [31:0]                rsp_tdata,
   output logic                       rsp_tlast,
   output ageg_pkg::pack_cmd_type     pk_cmd,
   input  ageg_pkg::pack_out_type     pk_out
);
   import ageg_pkg::*;

   seq_state_type        state_ff, state_in;
   logic [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic [SAMPLE_W-1:0]  prev_ff, prev_in;
   logic [ACC_W-1:0]     accum_ff, accum_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [32:0]          bound_ff, bound_in;
   logic [32:0]          shift_ff, shift_in;
   logic [3:0]           k_ff, k_in;
   logic                 esc_ff, esc_in;
   logic [WORD_W-1:0]    word_ff [2];
   logic [WORD_W-1:0]    word_in [2];
   logic [1:0]           nword_ff, nword_in;
   logic                 idx_ff, idx_in;

   logic [15:0] sample_mask;
   logic [32:0] adapt_sum;
   logic [31:0] adapt_half;
   logic [15:0] cnt_inc;
   logic        cnt_below;
   logic [20:0] cnt_mul;
   logic [3:0]  cap;
   logic        search_go;
   logic [15:0] quot;
   logic        quot_esc;
   logic [15:0] rem_bits;
   logic        last_word;

   assign sample_mask = 16'((17'd1 << cfg.depth) - 17'd1);
   assign adapt_sum   = {1'b0, accum_ff} + {17'd0, prev_ff};
   assign adapt_half  = 32'(({1'b0, adapt_sum} + 34'd1) >> 1);
   assign cnt_inc     = {1'b0, count_ff} + 16'd1;
   assign cnt_below   = {1'b0, count_ff} < {7'd0, cfg.limit};
   assign cnt_mul     = {6'd0, count_ff} * 21'd49;
   assign cap         = (cfg.depth >= 5'd2) ? 4'(cfg.depth - 5'd2) : 4'd0;
   assign search_go   = (k_ff < cap) && (shift_ff <= bound_ff);
   assign quot        = sample_ff >> k_ff;
   assign quot_esc    = quot >= {10'd0, cfg.umax};
   assign rem_bits    = sample_ff & 16'((17'd1 << k_ff) - 17'd1);
   assign last_word   = ({1'b0, idx_ff} + 2'd1) == nword_ff;

   assign rsp_tdata   = word_ff[idx_ff];
   assign rsp_tlast   = last_word;

   always_comb begin
      state_in   = state_ff;
      sample_in  = sample_ff;
      prev_in    = prev_ff;
      accum_in   = accum_ff;
      count_in   = count_ff;
      bound_in   = bound_ff;
      shift_in   = shift_ff;
      k_in       = k_ff;
      esc_in     = esc_ff;
      word_in    = word_ff;
      nword_in   = nword_ff;
      idx_in     = idx_ff;
      pk_cmd     = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      if (pk_out.valid) begin
         word_in[nword_ff[0]] = pk_out.word;
         nword_in             = nword_ff + 2'd1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               sample_in = req_sample & sample_mask;
               nword_in  = '0;
               idx_in    = 1'b0;
               unique case (req_kind_type'(req_kind))
                  REQ_IMAGE: state_in = ST_INIT;
                  REQ_BAND:  state_in = ST_RAW;
                  REQ_CODED: state_in = ST_ADAPT;
                  REQ_FLUSH: state_in = ST_FLUSH;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_INIT: begin
            count_in = CNT_W'(16'd1 << cfg.k0);
            accum_in = init_accum(cfg.k0);
            state_in = ST_RAW;
         end
         ST_RAW: begin
            pk_cmd.valid = 1'b1;
            pk_cmd.len   = {1'b0, cfg.depth};
            pk_cmd.value = {16'd0, sample_ff};
            prev_in      = sample_ff;
            state_in     = ST_EMIT;
         end
         ST_ADAPT: begin
            if (cnt_below) begin
               count_in = cnt_inc[CNT_W-1:0];
               accum_in = adapt_sum[32] ? '1 : adapt_sum[31:0];
            end else begin
               count_in = cnt_inc[CNT_W:1];
               accum_in = adapt_half;
            end
            state_in = ST_BOUND;
         end
         ST_BOUND: begin
            bound_in = {1'b0, accum_ff} + 33'(cnt_mul[20:7]);
            shift_in = {17'd0, count_ff, 1'b0};
            k_in     = '0;
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (search_go) begin
               k_in     = k_ff + 4'd1;
               shift_in = shift_ff << 1;
            end else begin
               state_in = ST_CODE1;
            end
         end
         ST_CODE1: begin
            esc_in       = quot_esc;
            pk_cmd.valid = 1'b1;
            pk_cmd.len   = quot_esc ? cfg.umax : quot[5:0];
            state_in     = ST_CODE2;
         end
         ST_CODE2: begin
            pk_cmd.valid = 1'b1;
            if (esc_ff) begin
               pk_cmd.len   = {1'b0, cfg.depth};
               pk_cmd.value = {16'd0, sample_ff};
            end else begin
               pk_cmd.len   = {2'd0, k_ff} + 6'd1;
               pk_cmd.value = (32'd1 << k_ff) | {16'd0, rem_bits};
            end
            prev_in  = sample_ff;
            state_in = ST_EMIT;
         end
         ST_FLUSH: begin
            pk_cmd.valid = 1'b1;
            pk_cmd.flush = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (nword_ff == 2'd0) begin
               state_in = ST_IDLE;
            end else begin
               rsp_tvalid = 1'b1;
               if (rsp_tready) begin
                  if (last_word) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nword_ff <= '0;
         idx_ff   <= 1'b0;
         prev_ff  <= '0;
         accum_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         nword_ff <= nword_in;
         idx_ff   <= idx_in;
         prev_ff  <= prev_in;
         accum_ff <= accum_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      bound_ff  <= bound_in;
      shift_ff  <= shift_in;
      k_ff      <= k_in;
      esc_ff    <= esc_in;
      word_ff   <= word_in;
   end

   `include "assert_macros.svh"

   `ASSERT_NEVER(a_nword_max, clock, reset, (nword_ff == 2'd3), "more than two words buffered")
   `ASSERT_HOLDS(a_k_cap, clock, reset, (state_ff == ST_SEARCH) |-> (k_ff <= cap), "code parameter above cap")
   `ASSERT_NEVER(a_busy_excl, clock, reset, (rsp_tvalid && req_tready), "result shown while taking input")
   `ASSERT_HOLDS(a_emit_words, clock, reset, (rsp_tvalid && rsp_tready && !last_word) |=> rsp_tvalid, "second word dropped")

endmodule

`default_nettype wire
